>>> rtl/cpf_pkg.sv
// Shared types and constants for the collision pair filter.
`timescale 1ns / 1ps
package cpf_pkg;

   // Item kinds
   localparam logic [1:0] KIND_CHECK  = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   localparam logic [14:0] CULL_RESET = 15'd50;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         type_a;
      logic [7:0]         type_b;
      logic               colliders_ok;
      logic signed [15:0] a_pos_x;
      logic signed [15:0] a_pos_y;
      logic signed [15:0] b_pos_x;
      logic signed [15:0] b_pos_y;
      logic [63:0]        a_rect;
      logic [63:0]        b_rect;
   } cpf_req_type;

   typedef struct packed {
      logic       collide;
      logic       table_full;
      logic [4:0] pair_count;
   } cpf_rsp_type;

   // Classified item handed from the front end to the table walker
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] type_a;
      logic [7:0] type_b;
      logic       geom_hit;
   } cpf_work_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_WALK,
      BK_APPLY
   } cpf_back_state_type;

endpackage

>>> rtl/collision_pair_filter_aabb.sv
// Top level of the collision pair filter with rectangle overlap test.
`timescale 1ns / 1ps
// Each item gives exactly one result, shown for one cycle on rsp_valid; the
// receiver cannot stall it. An item is taken when start is high and busy is
// low. The front end resolves the distance and overlap tests combinationally
// from its stage register and hands the item through a two-entry queue to the
// table walker, which reads the pair table through its single memory read
// port one slot per cycle; the front end and the queue can take new items
// while the walker is still busy with an earlier one. Reset empties the table at
// once through its valid bits; no clearing pass follows. cull_distance is
// written through the csr_ port, which is always ready.
module collision_pair_filter_aabb #(
   parameter int MAX_PAIRS = 16,
   parameter int TYPE_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cpf_pkg::cpf_req_type req_item,
   output logic                 rsp_valid,
   output cpf_pkg::cpf_rsp_type rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [14:0]          csr_data
);
   import cpf_pkg::*;

   logic [14:0]  cull_ff, cull_in;
   logic         q_full, q_empty, q_push, q_pop;
   cpf_work_type q_in_data, q_out_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cull_in = cull_ff;
      if (csr_valid && csr_ready) begin
         cull_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cull_ff <= CULL_RESET;
      end else begin
         cull_ff <= cull_in;
      end
   end

   cpf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .cull_distance (cull_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_in_data)
   );

   cpf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   cpf_back #(
      .MAX_PAIRS (MAX_PAIRS),
      .TYPE_BITS (TYPE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_out_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

>>> rtl/cpf_front.sv
// Front end: takes items and resolves the distance and rectangle overlap tests.
`timescale 1ns / 1ps
module cpf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cpf_pkg::cpf_req_type req_item,
   input  logic [14:0]          cull_distance,
   input  logic                 q_full,
   output logic                 q_push,
   output cpf_pkg::cpf_work_type q_data
);
   import cpf_pkg::*;

   cpf_req_type stage_ff, stage_in;
   logic        stage_vld_ff, stage_vld_in;
   logic        accept;

   logic signed [16:0] al, ar, at, ab, bl, br, bt, bb;
   logic signed [16:0] dx, dy;
   logic signed [17:0] dx_w, dy_w, lim, lim_neg;
   logic               far_x, far_y, overlap;

   assign q_push = stage_vld_ff && !q_full;
   assign busy   = stage_vld_ff && q_full;
   assign accept = start && !busy;

   always_comb begin
      stage_in     = stage_ff;
      stage_vld_in = stage_vld_ff;
      if (accept) begin
         stage_in     = req_item;
         stage_vld_in = 1'b1;
      end else if (q_push) begin
         stage_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   // Rectangle edges at 17 bits so right and bottom never wrap
   always_comb begin
      al = $signed({stage_ff.a_rect[63], stage_ff.a_rect[63:48]});
      at = $signed({stage_ff.a_rect[47], stage_ff.a_rect[47:32]});
      ar = al + $signed({stage_ff.a_rect[31], stage_ff.a_rect[31:16]});
      ab = at + $signed({stage_ff.a_rect[15], stage_ff.a_rect[15:0]});
      bl = $signed({stage_ff.b_rect[63], stage_ff.b_rect[63:48]});
      bt = $signed({stage_ff.b_rect[47], stage_ff.b_rect[47:32]});
      br = bl + $signed({stage_ff.b_rect[31], stage_ff.b_rect[31:16]});
      bb = bt + $signed({stage_ff.b_rect[15], stage_ff.b_rect[15:0]});
      overlap = !((al > br) || (ar < bl) || (at > bb) || (ab < bt));

      dx      = $signed({stage_ff.a_pos_x[15], stage_ff.a_pos_x})
              - $signed({stage_ff.b_pos_x[15], stage_ff.b_pos_x});
      dy      = $signed({stage_ff.a_pos_y[15], stage_ff.a_pos_y})
              - $signed({stage_ff.b_pos_y[15], stage_ff.b_pos_y});
      dx_w    = $signed({dx[16], dx});
      dy_w    = $signed({dy[16], dy});
      lim     = $signed({3'b000, cull_distance});
      lim_neg = -lim;
      far_x   = (dx_w > lim) || (dx_w < lim_neg);
      far_y   = (dy_w > lim) || (dy_w < lim_neg);
   end

   always_comb begin
      q_data.kind     = stage_ff.kind;
      q_data.type_a   = stage_ff.type_a;
      q_data.type_b   = stage_ff.type_b;
      q_data.geom_hit = stage_ff.colliders_ok && !(far_x && far_y) && overlap;
   end

endmodule

>>> rtl/cpf_queue.sv
// Two-entry queue between the front end and the table walker.
`timescale 1ns / 1ps
module cpf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cpf_pkg::cpf_work_type push_data,
   output logic                  full,
   input  logic                  pop,
   output cpf_pkg::cpf_work_type pop_data,
   output logic                  empty
);
   import cpf_pkg::*;

   cpf_work_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/cpf_back.sv
// Table walker: searches the pair table a slot per cycle and applies each item.
`timescale 1ns / 1ps
module cpf_back #(
   parameter int MAX_PAIRS = 16,
   parameter int TYPE_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  cpf_pkg::cpf_work_type q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   output cpf_pkg::cpf_rsp_type  rsp_item
);
   import cpf_pkg::*;

   localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CNT_W = $clog2(MAX_PAIRS + 1);
   localparam logic [IDX_W:0]   WALK_END = MAX_PAIRS[IDX_W:0];
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PAIRS - 1);

   cpf_back_state_type state_ff, state_in;
   cpf_work_type       work_ff, work_in;
   logic [IDX_W:0]     idx_ff, idx_in;
   logic               cmp_vld_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic [TYPE_BITS-1:0] rd_first_ff, rd_second_ff;
   logic               rd_valid_ff;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [MAX_PAIRS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W+4:0]   count_ext;
   cpf_rsp_type        rsp_ff, rsp_in;
   logic               rsp_vld_ff, rsp_vld_in;

   logic [TYPE_BITS-1:0] first_mem  [MAX_PAIRS];
   logic [TYPE_BITS-1:0] second_mem [MAX_PAIRS];
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx;

   logic [TYPE_BITS+7:0] ext_a, ext_b;
   logic [TYPE_BITS-1:0] key_a, key_b;
   logic                 issue, match;

   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

   // Only the low TYPE_BITS bits of a type take part
   assign ext_a = {{TYPE_BITS{1'b0}}, work_ff.type_a};
   assign ext_b = {{TYPE_BITS{1'b0}}, work_ff.type_b};
   assign key_a = ext_a[TYPE_BITS-1:0];
   assign key_b = ext_b[TYPE_BITS-1:0];

   assign issue = (state_ff == BK_WALK) && (idx_ff != WALK_END);
   assign match = rd_valid_ff &&
                  (((rd_first_ff == key_a) && (rd_second_ff == key_b)) ||
                   ((rd_first_ff == key_b) && (rd_second_ff == key_a)));

   always_comb begin
      state_in    = state_ff;
      work_in     = work_ff;
      idx_in      = idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      valid_in    = valid_ff;
      count_in    = count_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = 1'b0;
      q_pop       = 1'b0;
      wr_en       = 1'b0;
      wr_idx      = free_idx_ff;
      count_ext   = '0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               work_in  = q_data;
               idx_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = BK_WALK;
            end
         end
         BK_WALK: begin
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (cmp_vld_ff) begin
               // Keep the first matching slot and the lowest free slot
               if (match && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = cmp_idx_ff;
               end
               if (!rd_valid_ff && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == LAST_IDX) begin
                  state_in = BK_APPLY;
               end
            end
         end
         BK_APPLY: begin
            rsp_in.collide    = 1'b0;
            rsp_in.table_full = 1'b0;
            unique case (work_ff.kind)
               KIND_CHECK: begin
                  rsp_in.collide = work_ff.geom_hit && hit_ff;
               end
               KIND_ADD: begin
                  if (!hit_ff) begin
                     if (free_ff) begin
                        wr_en                 = 1'b1;
                        valid_in[free_idx_ff] = 1'b1;
                        count_in              = count_ff + 1'b1;
                     end else begin
                        rsp_in.table_full = 1'b1;
                     end
                  end
               end
               KIND_REMOVE: begin
                  if (hit_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                     count_in             = count_ff - 1'b1;
                  end
               end
               default: begin
                  // unused kind: report the count, change nothing
               end
            endcase
            count_ext         = {5'b00000, count_in};
            rsp_in.pair_count = count_ext[4:0];
            rsp_vld_in        = 1'b1;
            state_in          = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         idx_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
         valid_ff   <= '0;
         count_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         cmp_vld_ff <= issue;
         hit_ff     <= hit_in;
         free_ff    <= free_in;
         valid_ff   <= valid_in;
         count_ff   <= count_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
      cmp_idx_ff  <= idx_ff[IDX_W-1:0];
      rd_valid_ff <= valid_ff[idx_ff[IDX_W-1:0]];
   end

   // Pair table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         first_mem[wr_idx]  <= key_a;
         second_mem[wr_idx] <= key_b;
      end
      rd_first_ff  <= first_mem[idx_ff[IDX_W-1:0]];
      rd_second_ff <= second_mem[idx_ff[IDX_W-1:0]];
   end

endmodule

>>> rtl/cpf_checker.sv
// Port-level checks for the collision pair filter, bound to the top level.
`timescale 1ns / 1ps
module cpf_checker #(
   parameter int MAX_PAIRS = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 busy,
   input logic                 rsp_valid,
   input cpf_pkg::cpf_rsp_type rsp_item
);
   import cpf_pkg::*;

   localparam logic [4:0] FULL_COUNT = 5'(MAX_PAIRS);

   // a dropped add only happens with every slot taken
   a_full_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.table_full |-> rsp_item.pair_count == FULL_COUNT)
      else $error("table_full with free slots");

   a_flags_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.collide && rsp_item.table_full))
      else $error("collide and table_full together");

   // the walker returns to idle and walks the table between results, so results never come back to back
   a_rsp_spacing : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on consecutive cycles");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (MAX_PAIRS >= 31) || (rsp_item.pair_count <= FULL_COUNT))
      else $error("pair_count above table depth");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("activity right after reset");

endmodule

bind collision_pair_filter_aabb cpf_checker #(
   .MAX_PAIRS (MAX_PAIRS)
) u_cpf_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
